@@ hdl/alc_pkg.sv @@
// ----------------------------------------------------------------------------
// alc_pkg: shared types and constants of the ambient light lux calculator
// Field widths, segment tables, status codes and the divider cell beat.
// ----------------------------------------------------------------------------
package alc_pkg;

	localparam int FULL_W     = 16;
	localparam int SCALE_W    = 19;
	localparam int SCALE_FRAC = 10;
	localparam int CH_W       = 25;
	localparam int Q_W        = 12;
	localparam int REM_W      = CH_W + Q_W;
	localparam int SEG_W      = 10;
	localparam int PROD_W     = CH_W + SEG_W;
	localparam int LUX_W      = 20;
	localparam int LUX_FRAC   = 14;
	localparam int CFG_W      = 2;
	localparam int SEGMENTS   = 7;
	localparam int GAIN_SHIFT = 4;

	localparam logic [FULL_W-1:0]  SAT_LIMIT  = 16'd4900;
	localparam logic [SCALE_W-1:0] SCALE_13MS = 19'h07517;
	localparam logic [SCALE_W-1:0] SCALE_101MS = 19'h00FE7;
	localparam logic [SCALE_W-1:0] SCALE_UNITY = 19'h00400;

	localparam logic [CFG_W-1:0] REG_HIGH_GAIN = 2'd0;
	localparam logic [CFG_W-1:0] REG_INT_SEL   = 2'd1;
	localparam logic [CFG_W-1:0] REG_PKG_SEL   = 2'd2;

	localparam logic [1:0] INT_13MS  = 2'd0;
	localparam logic [1:0] INT_101MS = 2'd1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NO_IR = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	// one beat moving down the divider chain
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [CH_W-1:0]  d;
		logic [CH_W-1:0]  ch1;
		logic [Q_W-1:0]   q;
		logic             ovf;
		status_t          status;
	} div_beat_t;

	typedef struct packed {
		logic [SEG_W-1:0] b;
		logic [SEG_W-1:0] m;
	} seg_t;

	localparam logic [Q_W-1:0] KNEE_T [SEGMENTS] = '{
		12'h040, 12'h080, 12'h0C0, 12'h100, 12'h138, 12'h19A, 12'h29A};
	localparam logic [SEG_W-1:0] B_T [SEGMENTS] = '{
		10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018};
	localparam logic [SEG_W-1:0] M_T [SEGMENTS] = '{
		10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012};
	localparam logic [Q_W-1:0] KNEE_CS [SEGMENTS] = '{
		12'h043, 12'h085, 12'h0C8, 12'h10A, 12'h14D, 12'h19A, 12'h29A};
	localparam logic [SEG_W-1:0] B_CS [SEGMENTS] = '{
		10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037};
	localparam logic [SEG_W-1:0] M_CS [SEGMENTS] = '{
		10'h1AD, 10'h2C1, 10'h363, 10'h3DF, 10'h1DD, 10'h127, 10'h02B};

	// first segment whose knee is at or above the ratio; past the last knee b = m = 0
	function automatic seg_t seg_lookup(input logic cs, input logic [Q_W-1:0] ratio);
		seg_t s;
		s = '0;
		for (int i = SEGMENTS - 1; i >= 0; i--) begin
			if (cs) begin
				if (ratio <= KNEE_CS[i]) begin
					s.b = B_CS[i];
					s.m = M_CS[i];
				end
			end else begin
				if (ratio <= KNEE_T[i]) begin
					s.b = B_T[i];
					s.m = M_T[i];
				end
			end
		end
		return s;
	endfunction

endpackage

@@ hdl/alc_front.sv @@
// ----------------------------------------------------------------------------
// alc_front: input stage
// Scales both counts for gain and integration time, classifies the sample.
// ----------------------------------------------------------------------------
module alc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          high_gain,
	input  logic [1:0]                    int_sel,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [alc_pkg::FULL_W-1:0]    full_count,
	input  logic [alc_pkg::FULL_W-1:0]    ir_count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output alc_pkg::div_beat_t            out_beat
);

	localparam int PW = alc_pkg::FULL_W + alc_pkg::SCALE_W;

	logic [alc_pkg::SCALE_W-1:0] scale_base;
	logic [alc_pkg::SCALE_W-1:0] scale;
	logic [PW-1:0]               full_prod;
	logic [PW-1:0]               ir_prod;
	alc_pkg::status_t            status_nx;
	logic                        valid_s1;
	logic [alc_pkg::CH_W-1:0]    ch0_s1;
	logic [alc_pkg::CH_W-1:0]    ch1_s1;
	alc_pkg::status_t            status_s1;
	logic                        ovf;
	logic                        load;

	always_comb begin
		case (int_sel)
			alc_pkg::INT_13MS:  scale_base = alc_pkg::SCALE_13MS;
			alc_pkg::INT_101MS: scale_base = alc_pkg::SCALE_101MS;
			default:            scale_base = alc_pkg::SCALE_UNITY;
		endcase
	end

	// 1x gain: bring counts up to the 16x scale
	assign scale     = high_gain ? scale_base : (scale_base << alc_pkg::GAIN_SHIFT);
	assign full_prod = PW'(full_count) * PW'(scale);
	assign ir_prod   = PW'(ir_count) * PW'(scale);

	// floor(full / ir) < 2 is full < 2 * ir
	always_comb begin
		if (ir_count == '0)
			status_nx = alc_pkg::ST_NO_IR;
		else if (full_count > alc_pkg::SAT_LIMIT && {1'b0, full_count} < {ir_count, 1'b0})
			status_nx = alc_pkg::ST_SAT;
		else
			status_nx = alc_pkg::ST_OK;
	end

	assign in_ready = !valid_s1 || out_ready;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ch0_s1    <= full_prod[alc_pkg::SCALE_FRAC +: alc_pkg::CH_W];
			ch1_s1    <= ir_prod[alc_pkg::SCALE_FRAC +: alc_pkg::CH_W];
			status_s1 <= status_nx;
		end
	end

	// quotient needs more than Q_W bits when ch1 >= 4 * ch0; ratio is then past every knee
	assign ovf = (ch0_s1 != '0) && ({2'b00, ch1_s1} >= {ch0_s1, 2'b00});

	assign out_valid       = valid_s1;
	assign out_beat.rem    = (ch0_s1 == '0) ? '0 :
		{2'b00, ch1_s1, {(alc_pkg::REM_W - alc_pkg::CH_W - 2){1'b0}}};
	assign out_beat.d      = ch0_s1;
	assign out_beat.ch1    = ch1_s1;
	assign out_beat.q      = '0;
	assign out_beat.ovf    = ovf;
	assign out_beat.status = status_s1;

endmodule

@@ hdl/alc_div_cell.sv @@
// ----------------------------------------------------------------------------
// alc_div_cell: one restoring division step
// Develops one quotient bit of (ch1 << 10) / ch0 and passes the beat on.
// ----------------------------------------------------------------------------
module alc_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  alc_pkg::div_beat_t  in_beat,
	output logic                out_valid,
	input  logic                out_ready,
	output alc_pkg::div_beat_t  out_beat
);

	logic [alc_pkg::REM_W-1:0] dsh;
	logic [alc_pkg::REM_W-1:0] rem_sub;
	logic                      ge;
	alc_pkg::div_beat_t        beat_nx;
	alc_pkg::div_beat_t        beat_q;
	logic                      valid_q;

	// remainder is kept below d << Q_W, so the trial divisor is d << (Q_W - 1)
	assign dsh     = {1'b0, in_beat.d, {(alc_pkg::Q_W - 1){1'b0}}};
	assign ge      = in_beat.rem >= dsh;
	assign rem_sub = ge ? (in_beat.rem - dsh) : in_beat.rem;

	always_comb begin
		beat_nx     = in_beat;
		beat_nx.rem = {rem_sub[alc_pkg::REM_W-2:0], 1'b0};
		beat_nx.q   = {in_beat.q[alc_pkg::Q_W-2:0], ge};
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_q <= beat_nx;
		end
	end

	assign out_valid = valid_q;
	assign out_beat  = beat_q;

endmodule

@@ hdl/alc_back.sv @@
// ----------------------------------------------------------------------------
// alc_back: segment lookup, weighting and rounding
// Picks b and m from the ratio, forms full*b - ir*m, rounds to whole lux.
// ----------------------------------------------------------------------------
module alc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pkg_sel,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  alc_pkg::div_beat_t            in_beat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [alc_pkg::LUX_W-1:0]     lux,
	output logic [1:0]                    status
);

	localparam int SUM_W = alc_pkg::PROD_W + 1;
	localparam int RAW_W = SUM_W - alc_pkg::LUX_FRAC;

	logic [alc_pkg::Q_W:0]      ratio_sum;
	logic [alc_pkg::Q_W-1:0]    ratio;
	alc_pkg::seg_t              seg;

	logic                       valid_s1, valid_s2, valid_s3;
	logic                       rdy1, rdy2, rdy3;
	logic [alc_pkg::CH_W-1:0]   ch0_s1, ch1_s1;
	logic [alc_pkg::SEG_W-1:0]  b_s1, m_s1;
	alc_pkg::status_t           status_s1, status_s2, status_s3;
	logic [alc_pkg::PROD_W-1:0] pos_s2, neg_s2;
	logic [alc_pkg::LUX_W-1:0]  lux_s3;

	logic [alc_pkg::PROD_W-1:0] diff;
	logic [SUM_W-1:0]           rounded;
	logic [RAW_W-1:0]           raw;
	logic [alc_pkg::LUX_W-1:0]  lux_nx;

	assign ratio_sum = {1'b0, in_beat.q} + 1'b1;
	assign ratio     = ratio_sum[alc_pkg::Q_W:1];

	always_comb begin
		if (in_beat.ovf)
			seg = '0;
		else
			seg = alc_pkg::seg_lookup(pkg_sel, ratio);
	end

	assign rdy3     = !valid_s3 || out_ready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			ch0_s1    <= in_beat.d;
			ch1_s1    <= in_beat.ch1;
			b_s1      <= seg.b;
			m_s1      <= seg.m;
			status_s1 <= in_beat.status;
		end
		if (valid_s1 && rdy2) begin
			pos_s2    <= alc_pkg::PROD_W'(ch0_s1) * alc_pkg::PROD_W'(b_s1);
			neg_s2    <= alc_pkg::PROD_W'(ch1_s1) * alc_pkg::PROD_W'(m_s1);
			status_s2 <= status_s1;
		end
		if (valid_s2 && rdy3) begin
			lux_s3    <= lux_nx;
			status_s3 <= status_s2;
		end
	end

	// clamp negative to zero, round half up, saturate to the field
	assign diff    = (pos_s2 > neg_s2) ? (pos_s2 - neg_s2) : '0;
	assign rounded = {1'b0, diff} + SUM_W'(1 << (alc_pkg::LUX_FRAC - 1));
	assign raw     = rounded[SUM_W-1:alc_pkg::LUX_FRAC];

	always_comb begin
		if (status_s2 != alc_pkg::ST_OK)
			lux_nx = '0;
		else if (raw[RAW_W-1:alc_pkg::LUX_W] != '0)
			lux_nx = '1;
		else
			lux_nx = raw[alc_pkg::LUX_W-1:0];
	end

	assign out_valid = valid_s3;
	assign lux       = lux_s3;
	assign status    = status_s3;

endmodule

@@ hdl/ambient_light_lux_calc_unit.sv @@
// ----------------------------------------------------------------------------
// ambient_light_lux_calc_unit: photodiode ratio lux calculator
// Full/IR count pairs in, whole-lux value and status out.
// ----------------------------------------------------------------------------
// Takes one count pair per clock while in_ready is high and returns one
// result per pair, in order, through one scaling stage, a chain of 12
// divider cells (one per bit of the IR/full ratio), then segment lookup,
// multiply and rounding stages. Every stage has its own valid bit, so
// stalls on the output only back up as far as the first empty stage.
// Configuration registers reset to zero and are written with cfg_we;
// change them only while no beat is in flight.
module ambient_light_lux_calc_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [alc_pkg::CFG_W-1:0]     cfg_index,
	input  logic [1:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [alc_pkg::FULL_W-1:0]    full_count,
	input  logic [alc_pkg::FULL_W-1:0]    ir_count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [alc_pkg::LUX_W-1:0]     lux,
	output logic [1:0]                    status
);

	localparam int NCELL = alc_pkg::Q_W;

	logic               high_gain_q;
	logic [1:0]         int_sel_q;
	logic               pkg_sel_q;

	logic [NCELL:0]     cv;
	logic [NCELL:0]     cr;
	alc_pkg::div_beat_t cb [NCELL+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_gain_q <= 1'b0;
			int_sel_q   <= 2'd0;
			pkg_sel_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				alc_pkg::REG_HIGH_GAIN: high_gain_q <= cfg_data[0];
				alc_pkg::REG_INT_SEL:   int_sel_q   <= cfg_data;
				alc_pkg::REG_PKG_SEL:   pkg_sel_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	alc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.high_gain  (high_gain_q),
		.int_sel    (int_sel_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.full_count (full_count),
		.ir_count   (ir_count),
		.out_valid  (cv[0]),
		.out_ready  (cr[0]),
		.out_beat   (cb[0])
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		alc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[i]),
			.in_ready  (cr[i]),
			.in_beat   (cb[i]),
			.out_valid (cv[i+1]),
			.out_ready (cr[i+1]),
			.out_beat  (cb[i+1])
		);
	end

	alc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkg_sel   (pkg_sel_q),
		.in_valid  (cv[NCELL]),
		.in_ready  (cr[NCELL]),
		.in_beat   (cb[NCELL]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.lux       (lux),
		.status    (status)
	);

endmodule
